### rtl/ght_pkg.sv
// Shared opcodes, status codes, controller states and field widths for the handle table.
`timescale 1ns / 1ps
package ght_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned HIDX_W   = 10;
  localparam int unsigned HGEN_W   = 16;
  localparam int unsigned LIVE_W   = 11;
  localparam int unsigned IN_DW    = 64;
  localparam int unsigned OUT_DW   = 72;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ADD_WR,
    S_HND_CHK,
    S_HND_DEN,
    S_REM_MOV,
    S_REM_FREE,
    S_CLEAR,
    S_EMIT
  } state_e;

  // Field enables of one slot memory write
  typedef struct packed {
    logic used;
    logic link;
    logic gen;
  } slot_we_t;

endpackage

### rtl/ght_slot_mem.sv
// Per-slot memory: used flag, free/dense link and generation, one write and one read per cycle.
`timescale 1ns / 1ps
module ght_slot_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned IW    = 10,
  parameter int unsigned CW    = 11,
  parameter int unsigned GW    = 16
) (
  input  logic              clk_i,
  input  ght_pkg::slot_we_t we_i,
  input  logic [IW-1:0]     waddr_i,
  input  logic              wused_i,
  input  logic [CW-1:0]     wlink_i,
  input  logic [GW-1:0]     wgen_i,
  input  logic [IW-1:0]     raddr_i,
  output logic              rused_o,
  output logic [CW-1:0]     rlink_o,
  output logic [GW-1:0]     rgen_o
);

  logic          used_mem [DEPTH];
  logic [CW-1:0] link_mem [DEPTH];
  logic [GW-1:0] gen_mem  [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i.used) begin
      used_mem[waddr_i] <= wused_i;
    end
    if (we_i.link) begin
      link_mem[waddr_i] <= wlink_i;
    end
    if (we_i.gen) begin
      gen_mem[waddr_i] <= wgen_i;
    end
    rused_o <= used_mem[raddr_i];
    rlink_o <= link_mem[raddr_i];
    rgen_o  <= gen_mem[raddr_i];
  end

endmodule

### rtl/generational_handle_table.sv
// Channel  | Dir | Beat contents
// s_axis   | in  | tuser opcode; tdata entity_id, handle_index, handle_generation
// m_axis   | out | tuser status; tdata handle_index_res, handle_generation_res,
//          |     |   entity_id_res, live_count
// Add (S_ADD_WR), lookup (S_HND_CHK, S_HND_DEN) and remove (also S_REM_MOV,
// S_REM_FREE) chain dependent registered reads of the slot and dense memories; add
// and remove then write back. Clear sweeps the slot memory one entry a cycle.
// After reset an initializing pass writes every entry of the slot memory; no beat
// is taken until it ends. A result waits in the output register while the next
// beat is taken; the controller holds only if that register is still full.
`timescale 1ns / 1ps
module generational_handle_table #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned GEN_BITS = 16,
  parameter int unsigned ID_BITS  = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [31:0] entity_id, [41:32] handle_index, [57:42] handle_generation
  input  logic [ght_pkg::IN_DW-1:0]   s_axis_tdata_i,
  // [1:0] opcode
  input  logic [ght_pkg::OP_W-1:0]    s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [9:0] handle_index_res, [25:10] handle_generation_res, [57:26] entity_id_res,
  // [68:58] live_count
  output logic [ght_pkg::OUT_DW-1:0]  m_axis_tdata_o,
  // [1:0] status
  output logic [ght_pkg::STATUS_W-1:0] m_axis_tuser_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  ght_pkg::state_e state_q, state_d;

  // controller registers
  logic [CW-1:0]                   ctr_q, ctr_d;
  logic [CW-1:0]                   free_head_q, free_head_d;
  logic [CW-1:0]                   count_q, count_d;
  ght_pkg::opcode_e                op_q, op_d;
  logic [ID_BITS-1:0]              id_q, id_d;
  logic [IW-1:0]                   hidx_q, hidx_d;
  logic [ght_pkg::HGEN_W-1:0]      hgen_q, hgen_d;
  logic [IW-1:0]                   dptr_q, dptr_d;
  logic [GEN_BITS-1:0]             gen_q, gen_d;

  // pending result
  ght_pkg::status_e                res_status_q, res_status_d;
  logic [IW-1:0]                   res_idx_q, res_idx_d;
  logic [GEN_BITS-1:0]             res_gen_q, res_gen_d;
  logic [ID_BITS-1:0]              res_id_q, res_id_d;

  // output register
  logic                            out_valid_q;
  logic [ght_pkg::STATUS_W-1:0]    out_status_q;
  logic [ght_pkg::HIDX_W-1:0]      out_idx_q;
  logic [ght_pkg::HGEN_W-1:0]      out_gen_q;
  logic [ght_pkg::ID_W-1:0]        out_id_q;
  logic [ght_pkg::LIVE_W-1:0]      out_live_q;
  logic                            out_load;

  // slot memory port
  ght_pkg::slot_we_t               slot_we;
  logic [IW-1:0]                   slot_waddr, slot_raddr;
  logic                            slot_wused, slot_rused;
  logic [CW-1:0]                   slot_wlink, slot_rlink;
  logic [GEN_BITS-1:0]             slot_wgen, slot_rgen;

  // dense memory
  logic [ID_BITS-1:0]              dense_entity_mem [CAPACITY];
  logic [IW-1:0]                   dense_owner_mem  [CAPACITY];
  logic [GEN_BITS-1:0]             dense_ogen_mem   [CAPACITY];
  logic                            dense_we;
  logic [IW-1:0]                   dense_waddr, dense_raddr;
  logic [ID_BITS-1:0]              dense_wentity, dense_rentity;
  logic [IW-1:0]                   dense_wowner, dense_rowner;
  logic [GEN_BITS-1:0]             dense_wogen, dense_rogen;

  logic                            in_fire;
  logic [ght_pkg::ID_W-1:0]        in_id;
  logic [ght_pkg::HIDX_W-1:0]      in_hidx;
  logic [ght_pkg::HGEN_W-1:0]      in_hgen;
  logic                            hidx_in_range;
  logic                            table_full;
  logic                            slot_match;

  assign in_id   = s_axis_tdata_i[31:0];
  assign in_hidx = s_axis_tdata_i[41:32];
  assign in_hgen = s_axis_tdata_i[57:42];

  assign s_axis_tready_o = (state_q == ght_pkg::S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == ght_pkg::S_EMIT) && (!out_valid_q || m_axis_tready_i);

  assign hidx_in_range = 32'(in_hidx) < CAPACITY;
  assign table_full    = (32'(free_head_q) >= CAPACITY) || (32'(count_q) >= CAPACITY);
  assign slot_match    = (64'(slot_rgen) == 64'(hgen_q)) && slot_rused
                         && (32'(slot_rlink) < CAPACITY);

  ght_slot_mem #(
    .DEPTH (CAPACITY),
    .IW    (IW),
    .CW    (CW),
    .GW    (GEN_BITS)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wused_i (slot_wused),
    .wlink_i (slot_wlink),
    .wgen_i  (slot_wgen),
    .raddr_i (slot_raddr),
    .rused_o (slot_rused),
    .rlink_o (slot_rlink),
    .rgen_o  (slot_rgen)
  );

  always_ff @(posedge clk_i) begin
    if (dense_we) begin
      dense_entity_mem[dense_waddr] <= dense_wentity;
      dense_owner_mem[dense_waddr]  <= dense_wowner;
      dense_ogen_mem[dense_waddr]   <= dense_wogen;
    end
    dense_rentity <= dense_entity_mem[dense_raddr];
    dense_rowner  <= dense_owner_mem[dense_raddr];
    dense_rogen   <= dense_ogen_mem[dense_raddr];
  end

  always_comb begin
    state_d      = state_q;
    ctr_d        = ctr_q;
    free_head_d  = free_head_q;
    count_d      = count_q;
    op_d         = op_q;
    id_d         = id_q;
    hidx_d       = hidx_q;
    hgen_d       = hgen_q;
    dptr_d       = dptr_q;
    gen_d        = gen_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_gen_d    = res_gen_q;
    res_id_d     = res_id_q;

    slot_we       = '0;
    slot_waddr    = hidx_q;
    slot_wused    = 1'b0;
    slot_wlink    = free_head_q;
    slot_wgen     = gen_q + GEN_BITS'(1);
    slot_raddr    = hidx_q;
    dense_we      = 1'b0;
    dense_waddr   = dptr_q;
    dense_wentity = dense_rentity;
    dense_wowner  = dense_rowner;
    dense_wogen   = dense_rogen;
    dense_raddr   = dptr_q;

    case (state_q)
      ght_pkg::S_INIT: begin
        slot_we    = '{used: 1'b1, link: 1'b1, gen: 1'b1};
        slot_waddr = IW'(ctr_q);
        slot_wused = 1'b0;
        slot_wlink = ctr_q + CW'(1);
        slot_wgen  = GEN_BITS'(1);
        ctr_d      = ctr_q + CW'(1);
        if (32'(ctr_q) == CAPACITY - 1) begin
          state_d = ght_pkg::S_IDLE;
        end
      end

      ght_pkg::S_IDLE: begin
        slot_raddr = (ght_pkg::opcode_e'(s_axis_tuser_i) == ght_pkg::OP_ADD)
                     ? IW'(free_head_q) : IW'(in_hidx);
        if (in_fire) begin
          op_d         = ght_pkg::opcode_e'(s_axis_tuser_i);
          id_d         = ID_BITS'(in_id);
          hidx_d       = IW'(in_hidx);
          hgen_d       = in_hgen;
          res_status_d = ght_pkg::ST_OK;
          res_idx_d    = '0;
          res_gen_d    = '0;
          res_id_d     = '0;
          ctr_d        = '0;
          case (ght_pkg::opcode_e'(s_axis_tuser_i))
            ght_pkg::OP_ADD: begin
              if (table_full) begin
                res_status_d = ght_pkg::ST_FULL;
                state_d      = ght_pkg::S_EMIT;
              end else begin
                state_d = ght_pkg::S_ADD_WR;
              end
            end
            ght_pkg::OP_REMOVE, ght_pkg::OP_LOOKUP: begin
              if (hidx_in_range) begin
                state_d = ght_pkg::S_HND_CHK;
              end else begin
                res_status_d = ght_pkg::ST_INVALID;
                state_d      = ght_pkg::S_EMIT;
              end
            end
            ght_pkg::OP_CLEAR: state_d = ght_pkg::S_CLEAR;
            default: state_d = ght_pkg::S_IDLE;
          endcase
        end
      end

      ght_pkg::S_ADD_WR: begin
        // append to the dense array and link the head slot to it
        dense_we      = 1'b1;
        dense_waddr   = IW'(count_q);
        dense_wentity = id_q;
        dense_wowner  = IW'(free_head_q);
        dense_wogen   = slot_rgen;
        slot_we       = '{used: 1'b1, link: 1'b1, gen: 1'b0};
        slot_waddr    = IW'(free_head_q);
        slot_wused    = 1'b1;
        slot_wlink    = count_q;
        free_head_d   = slot_rlink;
        count_d       = count_q + CW'(1);
        res_idx_d     = IW'(free_head_q);
        res_gen_d     = slot_rgen;
        state_d       = ght_pkg::S_EMIT;
      end

      ght_pkg::S_HND_CHK: begin
        dptr_d      = IW'(slot_rlink);
        gen_d       = slot_rgen;
        dense_raddr = IW'(slot_rlink);
        if (slot_match) begin
          state_d = ght_pkg::S_HND_DEN;
        end else begin
          res_status_d = ght_pkg::ST_INVALID;
          state_d      = ght_pkg::S_EMIT;
        end
      end

      ght_pkg::S_HND_DEN: begin
        dense_raddr = IW'(count_q - CW'(1));
        if (dense_rogen != gen_q) begin
          res_status_d = ght_pkg::ST_INVALID;
          state_d      = ght_pkg::S_EMIT;
        end else if (op_q == ght_pkg::OP_LOOKUP) begin
          res_id_d = dense_rentity;
          state_d  = ght_pkg::S_EMIT;
        end else begin
          state_d = ght_pkg::S_REM_MOV;
        end
      end

      ght_pkg::S_REM_MOV: begin
        // move the last dense entry into the hole and repoint its slot
        dense_we    = 1'b1;
        dense_waddr = dptr_q;
        slot_we     = '{used: 1'b0, link: 1'b1, gen: 1'b0};
        slot_waddr  = dense_rowner;
        slot_wlink  = CW'(dptr_q);
        state_d     = ght_pkg::S_REM_FREE;
      end

      ght_pkg::S_REM_FREE: begin
        slot_we     = '{used: 1'b1, link: 1'b1, gen: 1'b1};
        slot_waddr  = hidx_q;
        slot_wused  = 1'b0;
        slot_wlink  = free_head_q;
        slot_wgen   = gen_q + GEN_BITS'(1);
        free_head_d = CW'(hidx_q);
        count_d     = count_q - CW'(1);
        state_d     = ght_pkg::S_EMIT;
      end

      ght_pkg::S_CLEAR: begin
        // read slot ctr while writing back slot ctr-1
        slot_raddr = IW'(ctr_q);
        if (ctr_q != '0) begin
          slot_we    = '{used: 1'b1, link: 1'b1, gen: 1'b1};
          slot_waddr = IW'(ctr_q - CW'(1));
          slot_wused = 1'b0;
          slot_wlink = ctr_q;
          slot_wgen  = slot_rgen + GEN_BITS'(1);
        end
        ctr_d = ctr_q + CW'(1);
        if (32'(ctr_q) == CAPACITY) begin
          free_head_d = '0;
          count_d     = '0;
          state_d     = ght_pkg::S_EMIT;
        end
      end

      ght_pkg::S_EMIT: begin
        if (out_load) begin
          state_d = ght_pkg::S_IDLE;
        end
      end

      default: state_d = ght_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ght_pkg::S_INIT;
      ctr_q       <= '0;
      free_head_q <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctr_q       <= ctr_d;
      free_head_q <= free_head_d;
      count_q     <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_d_hold: begin
      op_q         <= op_d;
      id_q         <= id_d;
      hidx_q       <= hidx_d;
      hgen_q       <= hgen_d;
      dptr_q       <= dptr_d;
      gen_q        <= gen_d;
      res_status_q <= res_status_d;
      res_idx_q    <= res_idx_d;
      res_gen_q    <= res_gen_d;
      res_id_q     <= res_id_d;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_idx_q    <= ght_pkg::HIDX_W'(res_idx_q);
      out_gen_q    <= ght_pkg::HGEN_W'(res_gen_q);
      out_id_q     <= ght_pkg::ID_W'(res_id_q);
      out_live_q   <= ght_pkg::LIVE_W'(count_q);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {3'b000, out_live_q, out_id_q, out_gen_q, out_idx_q};

endmodule
